// ===== sv/iate_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the array table engine.
package iate_pkg;

	localparam int DEPTH     = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int OP_W      = 3;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int FIDX_W    = 7;
	localparam int STAT_W    = 2;
	localparam int FILL_W    = 7;
	localparam int CAP_W     = 7;
	localparam int CAP_RESET = 64;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
	localparam logic [OP_W-1:0] OP_GET    = 3'd3;
	localparam logic [OP_W-1:0] OP_SET    = 3'd4;
	localparam logic [OP_W-1:0] OP_SUM    = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [1:0] PTR_CNT  = 2'd0;
	localparam logic [1:0] PTR_POS  = 2'd1;
	localparam logic [1:0] PTR_ZERO = 2'd2;

	localparam logic [1:0] WR_VAL_POS    = 2'd0;
	localparam logic [1:0] WR_FIRST_FIDX = 2'd1;
	localparam logic [1:0] WR_VAL_ZERO   = 2'd2;

	typedef struct packed {
		logic              load;
		logic              ptr_ld;
		logic [1:0]        ptr_sel;
		logic              step;
		logic              rd_here;
		logic              cap_rd;
		logic              res_ones;
		logic              wr_en;
		logic [1:0]        wr_sel;
		logic              cnt_inc;
		logic              cnt_dec;
		logic              stat_we;
		logic [STAT_W-1:0] stat;
		logic              fidx_hit;
		logic              fidx_miss;
		logic              out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            pos_gt_cnt;
		logic            pos_lt_cnt;
		logic            full;
		logic            ptr_eq_pos;
		logic            ptr_lt_cnt;
		logic            ptr1_lt_cnt;
		logic            hit;
		logic            out_free;
	} dp_sts_t;

endpackage

// ===== sv/iate_dp.sv =====
// Datapath: entry memory, fill count, walk pointer, result and output registers.
module iate_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [iate_pkg::OP_W-1:0]          opcode,
	input  logic [iate_pkg::POS_W-1:0]         position,
	input  logic signed [iate_pkg::VAL_W-1:0]  operand_value,
	input  logic                               cfg_wr_en,
	input  logic [iate_pkg::CAP_W-1:0]         cfg_wr_data,
	input  iate_pkg::dp_cmd_t                  cmd,
	output iate_pkg::dp_sts_t                  sts,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic signed [iate_pkg::VAL_W-1:0]  read_value,
	output logic signed [iate_pkg::FIDX_W-1:0] found_index,
	output logic [iate_pkg::STAT_W-1:0]        status,
	output logic [iate_pkg::FILL_W-1:0]        fill_level
);
	import iate_pkg::*;

	logic [DATA_W-1:0] entry_mem_q [DEPTH];

	logic [OP_W-1:0]   op_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [DATA_W-1:0] rdata_q;
	logic              scan_s1;
	logic [CNT_W-1:0]  idx_s1;
	logic              pend_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic [DATA_W-1:0] first_q;
	logic [DATA_W-1:0] res_val_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [STAT_W-1:0] stat_q;

	logic              out_valid_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [FIDX_W-1:0] out_fidx_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [FILL_W-1:0] out_fill_q;

	logic              is_ins;
	logic              is_shift;
	logic              is_scan;
	logic              hit;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign is_ins   = (op_q == OP_INSERT);
	assign is_shift = is_ins || (op_q == OP_DELETE);
	assign is_scan  = (op_q == OP_SEARCH) || (op_q == OP_SUM);
	assign hit      = scan_s1 && (op_q == OP_SEARCH) && (rdata_q == val_q);

	// insert pulls from below the pointer, delete from above it
	always_comb begin
		rd_en = cmd.step || cmd.rd_here;
		if (cmd.rd_here) begin
			rd_addr = ADDR_W'(pos_q);
		end else if (is_ins) begin
			rd_addr = ADDR_W'(ptr_q - CNT_W'(1));
		end else if (op_q == OP_DELETE) begin
			rd_addr = ADDR_W'(ptr_q + CNT_W'(1));
		end else begin
			rd_addr = ADDR_W'(ptr_q);
		end
	end

	// a pending shift write never coincides with a commanded write
	always_comb begin
		wr_en   = pend_s1 || cmd.wr_en;
		wr_addr = ADDR_W'(pos_q);
		wr_data = val_q;
		if (pend_s1) begin
			wr_addr = wa_s1;
			wr_data = rdata_q;
		end else begin
			unique case (cmd.wr_sel)
				WR_VAL_POS: begin
					wr_addr = ADDR_W'(pos_q);
					wr_data = val_q;
				end
				WR_FIRST_FIDX: begin
					wr_addr = ADDR_W'(fidx_q);
					wr_data = first_q;
				end
				WR_VAL_ZERO: begin
					wr_addr = '0;
					wr_data = val_q;
				end
				default: begin
					wr_addr = ADDR_W'(pos_q);
					wr_data = val_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= entry_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cap_q       <= CAP_W'(CAP_RESET);
			scan_s1     <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			scan_s1 <= cmd.step && is_scan;
			pend_s1 <= cmd.step && is_shift;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			pos_q <= position;
			val_q <= DATA_W'(operand_value);
		end
		if (cmd.ptr_ld) begin
			unique case (cmd.ptr_sel)
				PTR_CNT:  ptr_q <= cnt_q;
				PTR_POS:  ptr_q <= CNT_W'(pos_q);
				PTR_ZERO: ptr_q <= '0;
				default:  ptr_q <= '0;
			endcase
		end else if (cmd.step) begin
			ptr_q <= is_ins ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
		end
		idx_s1 <= ptr_q;
		wa_s1  <= ADDR_W'(ptr_q);
		if (scan_s1 && idx_s1 == '0) begin
			first_q <= rdata_q;
		end

		if (cmd.load) begin
			res_val_q <= '0;
		end else if (cmd.cap_rd) begin
			res_val_q <= rdata_q;
		end else if (cmd.res_ones) begin
			res_val_q <= '1;
		end else if (scan_s1 && op_q == OP_SUM) begin
			res_val_q <= res_val_q + rdata_q;
		end

		if (cmd.load) begin
			fidx_q <= '0;
		end else if (cmd.fidx_hit) begin
			fidx_q <= FIDX_W'(idx_s1);
		end else if (cmd.fidx_miss) begin
			fidx_q <= '1;
		end

		if (cmd.load) begin
			stat_q <= ST_OK;
		end else if (cmd.stat_we) begin
			stat_q <= cmd.stat;
		end

		if (cmd.out_load) begin
			out_val_q  <= VAL_W'(res_val_q);
			out_fidx_q <= fidx_q;
			out_stat_q <= stat_q;
			out_fill_q <= FILL_W'(cnt_q);
		end
	end

	always_comb begin
		sts.op          = op_q;
		sts.pos_gt_cnt  = 32'(pos_q) > 32'(cnt_q);
		sts.pos_lt_cnt  = 32'(pos_q) < 32'(cnt_q);
		sts.full        = (32'(cnt_q) >= 32'(cap_q)) || (32'(cnt_q) >= DEPTH);
		sts.ptr_eq_pos  = 32'(ptr_q) == 32'(pos_q);
		sts.ptr_lt_cnt  = ptr_q < cnt_q;
		sts.ptr1_lt_cnt = (32'(ptr_q) + 32'd1) < 32'(cnt_q);
		sts.hit         = hit;
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign read_value  = out_val_q;
	assign found_index = out_fidx_q;
	assign status      = out_stat_q;
	assign fill_level  = out_fill_q;

endmodule

// ===== sv/iate_ctrl.sv =====
// Controller: sequences each request over the datapath and drives the input stall.
module iate_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  iate_pkg::dp_sts_t sts,
	output iate_pkg::dp_cmd_t cmd
);
	import iate_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DEC     = 4'd1;
	localparam logic [3:0] S_INS     = 4'd2;
	localparam logic [3:0] S_INS_PUT = 4'd3;
	localparam logic [3:0] S_DEL_CAP = 4'd4;
	localparam logic [3:0] S_DEL_SH  = 4'd5;
	localparam logic [3:0] S_GET_CAP = 4'd6;
	localparam logic [3:0] S_SRCH    = 4'd7;
	localparam logic [3:0] S_SWAP1   = 4'd8;
	localparam logic [3:0] S_SWAP2   = 4'd9;
	localparam logic [3:0] S_SUM     = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_DONE;
				case (sts.op)
					OP_INSERT: begin
						if (sts.pos_gt_cnt) begin
							cmd.stat_we = 1'b1;
							cmd.stat    = ST_BAD_INDEX;
						end else if (sts.full) begin
							cmd.stat_we = 1'b1;
							cmd.stat    = ST_FULL;
						end else begin
							cmd.ptr_ld  = 1'b1;
							cmd.ptr_sel = PTR_CNT;
							state_d     = S_INS;
						end
					end
					OP_DELETE: begin
						if (sts.pos_lt_cnt) begin
							cmd.rd_here = 1'b1;
							cmd.ptr_ld  = 1'b1;
							cmd.ptr_sel = PTR_POS;
							state_d     = S_DEL_CAP;
						end else begin
							cmd.stat_we = 1'b1;
							cmd.stat    = ST_BAD_INDEX;
						end
					end
					OP_SEARCH: begin
						cmd.ptr_ld  = 1'b1;
						cmd.ptr_sel = PTR_ZERO;
						state_d     = S_SRCH;
					end
					OP_GET: begin
						if (sts.pos_lt_cnt) begin
							cmd.rd_here = 1'b1;
							state_d     = S_GET_CAP;
						end else begin
							cmd.res_ones = 1'b1;
							cmd.stat_we  = 1'b1;
							cmd.stat     = ST_BAD_INDEX;
						end
					end
					OP_SET: begin
						if (sts.pos_lt_cnt) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_VAL_POS;
						end else begin
							cmd.stat_we = 1'b1;
							cmd.stat    = ST_BAD_INDEX;
						end
					end
					OP_SUM: begin
						cmd.ptr_ld  = 1'b1;
						cmd.ptr_sel = PTR_ZERO;
						state_d     = S_SUM;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_INS: begin
				// last shifted word lands during the cycle the pointer meets the position
				if (sts.ptr_eq_pos) begin
					state_d = S_INS_PUT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_INS_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_VAL_POS;
				cmd.cnt_inc = 1'b1;
				state_d     = S_DONE;
			end
			S_DEL_CAP: begin
				cmd.cap_rd = 1'b1;
				state_d    = S_DEL_SH;
			end
			S_DEL_SH: begin
				if (sts.ptr1_lt_cnt) begin
					cmd.step = 1'b1;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_GET_CAP: begin
				cmd.cap_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_SRCH: begin
				if (sts.hit) begin
					cmd.fidx_hit = 1'b1;
					state_d      = S_SWAP1;
				end else if (sts.ptr_lt_cnt) begin
					cmd.step = 1'b1;
				end else begin
					cmd.fidx_miss = 1'b1;
					cmd.stat_we   = 1'b1;
					cmd.stat      = ST_NOT_FOUND;
					state_d       = S_DONE;
				end
			end
			S_SWAP1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_FIRST_FIDX;
				state_d    = S_SWAP2;
			end
			S_SWAP2: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_VAL_ZERO;
				state_d    = S_DONE;
			end
			S_SUM: begin
				// final word is added on the edge that leaves this state
				if (sts.ptr_lt_cnt) begin
					cmd.step = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== sv/indexed_array_table_engine.sv =====
// Top level: packed array table with insert, delete, search, get, set and sum.
// Insert, delete and sum walk one entry per cycle through the single memory read port; a
// search hit then swaps the found entry with entry 0 in S_SWAP1 and S_SWAP2. One request in
// flight; the next beat is taken back in S_IDLE after the result loads, later while out_stall
// holds the output register.
// Reset clears fill count, capacity (to 64) and control; entry contents are not cleared.
module indexed_array_table_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [iate_pkg::OP_W-1:0]          opcode,
	input  logic [iate_pkg::POS_W-1:0]         position,
	input  logic signed [iate_pkg::VAL_W-1:0]  operand_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [iate_pkg::VAL_W-1:0]  read_value,
	output logic signed [iate_pkg::FIDX_W-1:0] found_index,
	output logic [iate_pkg::STAT_W-1:0]        status,
	output logic [iate_pkg::FILL_W-1:0]        fill_level,
	input  logic                               cfg_wr_en,
	input  logic [iate_pkg::CAP_W-1:0]         cfg_wr_data
);
	import iate_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	iate_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	iate_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (opcode),
		.position      (position),
		.operand_value (operand_value),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.read_value    (read_value),
		.found_index   (found_index),
		.status        (status),
		.fill_level    (fill_level)
	);

endmodule

// ===== sv/iate_checker.sv =====
// Port-level checker for the array table engine, bound to the top level.
module iate_props (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [iate_pkg::VAL_W-1:0]  read_value,
	input logic signed [iate_pkg::FIDX_W-1:0] found_index,
	input logic [iate_pkg::STAT_W-1:0]        status,
	input logic [iate_pkg::FILL_W-1:0]        fill_level
);
	import iate_pkg::*;

	// held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status)
			&& $stable(found_index) && $stable(fill_level))
		else $error("result beat changed while stalled");

	// one request at a time: busy right after taking a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a request is in progress");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOT_FOUND |-> found_index == '1 && read_value == '0)
		else $error("search miss fields wrong");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(fill_level) <= DEPTH)
		else $error("fill level above depth");

	a_full_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> fill_level != '0 || found_index == '0)
		else $error("store full reported with odd fields");

endmodule

bind indexed_array_table_engine iate_props u_iate_props (.*);
